/* sv/sfsr_pkg.sv */
// Shared types and constants of the stream fair-share release regulator.
package sfsr_pkg;

  localparam int MAX_STREAMS = 8;
  localparam int SW          = 3;
  localparam int RUN_MAX     = 64;
  localparam int KW          = 7;
  localparam int CAPW        = 7;
  localparam int SIUW        = 4;
  localparam int NW          = 4;
  localparam int NUMW        = CAPW + 2;
  localparam int DENW        = SW + 2;

  localparam logic [CAPW-1:0] RESET_CAP   = 7'd32;
  localparam logic [SIUW-1:0] RESET_SIU   = 4'd8;
  localparam int              RESET_LIMIT = 4;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_REL = 2'd1,
    OP_CMP = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic {
    STAT_RELEASED = 1'b0,
    STAT_DROPPED  = 1'b1
  } status_e;

  typedef enum logic {
    REG_TCAP = 1'b0,
    REG_SIU  = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REL_SCAN,
    S_REL_CAPT,
    S_REL_FLUSH,
    S_RB_SUM,
    S_RB_SORT,
    S_RB_DIV,
    S_RB_WAIT,
    S_RB_DECIDE,
    S_RB_ALL,
    S_RB_HI,
    S_RB_LO
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } div_req_t;

endpackage

/* sv/sfsr_if.sv */
// Stream channel interfaces for items in and results out.
interface sfsr_in_if #(parameter int TAG_BITS = 16) ();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [2:0]          stream;
  logic [TAG_BITS-1:0] tag;
  modport source (output valid, operation, stream, tag, input ready);
  modport sink (input valid, operation, stream, tag, output ready);
endinterface

interface sfsr_out_if #(parameter int TAG_BITS = 16) ();
  logic                valid;
  logic                ready;
  logic [2:0]          out_stream;
  logic [TAG_BITS-1:0] out_tag;
  logic                status;
  logic                last;
  modport source (output valid, out_stream, out_tag, status, last, input ready);
  modport sink (input valid, out_stream, out_tag, status, last, output ready);
endinterface

/* sv/sfsr_tag_ram.sv */
// Tag store: one write port, one registered read port.
module sfsr_tag_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int W     = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/sfsr_div.sv */
// Restoring divider, one quotient bit per cycle.
module sfsr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfsr_pkg::div_req_t        req_i,
  output logic                      done_o,
  output logic [sfsr_pkg::NUMW-1:0] quo_o
);
  localparam int CW = $clog2(sfsr_pkg::NUMW + 1);

  logic [sfsr_pkg::NUMW-1:0] quo_q, quo_d;
  logic [sfsr_pkg::DENW:0]   rem_q, rem_d;
  logic [sfsr_pkg::DENW-1:0] den_q, den_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [sfsr_pkg::DENW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[sfsr_pkg::DENW-1:0], quo_q[sfsr_pkg::NUMW-1]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CW'(sfsr_pkg::NUMW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract where it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[sfsr_pkg::NUMW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[sfsr_pkg::NUMW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* sv/stream_fair_share_release_regulator_top.sv */
// Stream fair-share release regulator: per-stream tag queues with fair in-flight limits.
// Enqueue and completion are taken in the idle state; a dropped enqueue shows its result the next cycle.
// Release: each transfer reads the tag store, then captures the tag when the pending slot
//   is free; blocked streams are skipped, a flush ends it; at most 64 transfers per release.
// Rebalance every total_capacity completions on active streams: sum, sort, then division steps
//   (divider is bit-serial); no item is taken meanwhile.
// Reset: queues empty, limits 4, identity order; the tag store is not cleared.
module stream_fair_share_release_regulator_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfsr_in_if.sink     in_i,
  sfsr_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  localparam int MS    = sfsr_pkg::MAX_STREAMS;
  localparam int SW    = sfsr_pkg::SW;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int LW    = (FW > 8) ? FW : 8;
  localparam int LEFTW = FW + SW;
  localparam int DEPTH = MS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = sfsr_pkg::NW;

  // configuration registers
  logic [sfsr_pkg::CAPW-1:0] tcap_q;
  logic [sfsr_pkg::SIUW-1:0] siu_q;
  logic                      cfg_we;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcap_q <= sfsr_pkg::RESET_CAP;
      siu_q  <= sfsr_pkg::RESET_SIU;
    end else if (cfg_we) begin
      if (paddr_i[2] == sfsr_pkg::REG_TCAP) begin
        tcap_q <= pwdata_i[sfsr_pkg::CAPW-1:0];
      end else begin
        siu_q <= pwdata_i[sfsr_pkg::SIUW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr_i[2] == sfsr_pkg::REG_TCAP) begin
      prdata_o = 32'(tcap_q);
    end else begin
      prdata_o = 32'(siu_q);
    end
  end

  // active stream count: zero acts as one, clamp at the stream maximum
  logic [NW-1:0] n;
  logic [NW-1:0] nm2;
  always_comb begin
    if (siu_q == '0) begin
      n = NW'(1);
    end else if (siu_q > sfsr_pkg::SIUW'(MS)) begin
      n = NW'(MS);
    end else begin
      n = NW'(siu_q);
    end
    nm2 = n - NW'(2);
  end

  // state
  sfsr_pkg::state_e state_q, state_d;
  logic [QW-1:0]             head_q [MS];
  logic [QW-1:0]             head_d [MS];
  logic [FW-1:0]             fill_q [MS];
  logic [FW-1:0]             fill_d [MS];
  logic [LW-1:0]             infl_q [MS];
  logic [LW-1:0]             infl_d [MS];
  logic [LW-1:0]             lim_q  [MS];
  logic [LW-1:0]             lim_d  [MS];
  logic [SW-1:0]             ord_q  [MS];
  logic [SW-1:0]             ord_d  [MS];
  logic [sfsr_pkg::CAPW-1:0] comp_q, comp_d;
  logic [NW-1:0]             p_q, p_d;
  logic [sfsr_pkg::KW-1:0]   k_q, k_d;
  logic                      pend_v_q, pend_v_d;
  logic [SW-1:0]             pend_s_q, pend_s_d;
  logic [TAG_BITS-1:0]       pend_t_q, pend_t_d;
  logic [SW-1:0]             rd_s_q, rd_s_d;
  logic [LEFTW-1:0]          left_q, left_d;
  logic [sfsr_pkg::CAPW-1:0] cap_q, cap_d;
  logic [NW-1:0]             lo_q, lo_d, hie_q, hie_d;
  logic [LW-1:0]             avg_q, avg_d;
  logic [SW-1:0]             j_q, j_d, pass_q, pass_d;
  logic                      sort2_q, sort2_d;

  // output register
  logic                out_v_q, out_v_d;
  logic [SW-1:0]       out_s_q, out_s_d;
  logic [TAG_BITS-1:0] out_t_q, out_t_d;
  logic                out_st_q, out_st_d;
  logic                out_l_q, out_l_d;
  logic                out_ld;

  assign out_ld          = !out_v_q || out_o.ready;
  assign out_o.valid     = out_v_q;
  assign out_o.out_stream = out_s_q;
  assign out_o.out_tag   = out_t_q;
  assign out_o.status    = out_st_q;
  assign out_o.last      = out_l_q;

  // tag store and divider
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [TAG_BITS-1:0]       ram_rdata;
  sfsr_pkg::div_req_t        div_req;
  logic                      div_done;
  logic [sfsr_pkg::NUMW-1:0] div_quo;

  sfsr_tag_ram #(.DEPTH(DEPTH), .AW(AW), .W(TAG_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.tag),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // shared decode
  logic                   in_acc;
  sfsr_pkg::op_e          op;
  logic [SW-1:0]          s_in;
  logic                   s_act;
  logic [sfsr_pkg::CAPW:0] comp_inc;
  logic                   comp_hit;
  logic [SW-1:0]          id;
  logic                   id_ok;
  logic                   scan_end;
  logic [SW-1:0]          lo_id, hi_id, sa, sb;
  logic [LW-1:0]          f_lo, f_hi, ka, kb;
  logic                   all_cond, hi_step, lo_step;
  logic                   sort_end;
  logic [NW-1:0]          hie_m1;

  assign in_i.ready = (state_q == sfsr_pkg::S_IDLE) && out_ld;
  assign in_acc     = in_i.valid && in_i.ready;
  assign op         = sfsr_pkg::op_e'(in_i.operation);
  assign s_in       = in_i.stream;
  assign s_act      = NW'(s_in) < n;
  assign comp_inc   = {1'b0, comp_q} + 1'b1;
  assign comp_hit   = comp_inc >= {1'b0, tcap_q};

  always_comb begin
    id       = ord_q[p_q[SW-1:0]];
    id_ok    = (NW'(id) < n) && (fill_q[id] != '0) && (infl_q[id] < lim_q[id]);
    scan_end = (p_q >= n) || (k_q == sfsr_pkg::KW'(sfsr_pkg::RUN_MAX));
    hie_m1   = hie_q - 1'b1;
    lo_id    = ord_q[lo_q[SW-1:0]];
    hi_id    = ord_q[hie_m1[SW-1:0]];
    f_lo     = LW'(fill_q[lo_id]);
    f_hi     = LW'(fill_q[hi_id]);
    all_cond = (f_lo >= avg_q) || (f_hi <= avg_q);
    hi_step  = (hie_q > lo_q) && (f_hi >= avg_q);
    lo_step  = (hie_q > lo_q) && (f_lo <= avg_q);
    sa       = ord_q[j_q];
    sb       = ord_q[j_q + 1'b1];
    ka       = sort2_q ? lim_q[sa] : LW'(fill_q[sa]);
    kb       = sort2_q ? lim_q[sb] : LW'(fill_q[sb]);
    sort_end = (NW'(j_q) == nm2) && (NW'(pass_q) == nm2);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfsr_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op)
            sfsr_pkg::OP_REL: state_d = sfsr_pkg::S_REL_SCAN;
            sfsr_pkg::OP_CMP: begin
              if (s_act && comp_hit) state_d = sfsr_pkg::S_RB_SUM;
            end
            default: state_d = sfsr_pkg::S_IDLE;
          endcase
        end
      end
      sfsr_pkg::S_REL_SCAN: begin
        if (scan_end) state_d = sfsr_pkg::S_REL_FLUSH;
        else if (id_ok) state_d = sfsr_pkg::S_REL_CAPT;
      end
      sfsr_pkg::S_REL_CAPT: begin
        if (!pend_v_q || out_ld) state_d = sfsr_pkg::S_REL_SCAN;
      end
      sfsr_pkg::S_REL_FLUSH: begin
        if (!pend_v_q || out_ld) state_d = sfsr_pkg::S_IDLE;
      end
      sfsr_pkg::S_RB_SUM: begin
        if (p_q >= n) begin
          state_d = (n == NW'(1)) ? sfsr_pkg::S_RB_DIV : sfsr_pkg::S_RB_SORT;
        end
      end
      sfsr_pkg::S_RB_SORT: begin
        if (sort_end) state_d = sort2_q ? sfsr_pkg::S_IDLE : sfsr_pkg::S_RB_DIV;
      end
      sfsr_pkg::S_RB_DIV:  state_d = sfsr_pkg::S_RB_WAIT;
      sfsr_pkg::S_RB_WAIT: begin
        if (div_done) state_d = sfsr_pkg::S_RB_DECIDE;
      end
      sfsr_pkg::S_RB_DECIDE: begin
        if (all_cond) state_d = sfsr_pkg::S_RB_ALL;
        else if (left_q <= LEFTW'(cap_q)) state_d = sfsr_pkg::S_RB_HI;
        else state_d = sfsr_pkg::S_RB_LO;
      end
      sfsr_pkg::S_RB_ALL: begin
        if (p_q + 1'b1 == hie_q) begin
          state_d = (n == NW'(1)) ? sfsr_pkg::S_IDLE : sfsr_pkg::S_RB_SORT;
        end
      end
      sfsr_pkg::S_RB_HI, sfsr_pkg::S_RB_LO: begin
        if (!((state_q == sfsr_pkg::S_RB_HI) ? hi_step : lo_step)) begin
          if (lo_q < hie_q) state_d = sfsr_pkg::S_RB_DIV;
          else state_d = (n == NW'(1)) ? sfsr_pkg::S_IDLE : sfsr_pkg::S_RB_SORT;
        end
      end
      default: state_d = sfsr_pkg::S_IDLE;
    endcase
  end

  // datapath
  logic [FW:0]     wsum;
  logic [QW-1:0]   wpos;
  logic [LW:0]     fw;
  logic [SW-1:0]   wid;

  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    infl_d   = infl_q;
    lim_d    = lim_q;
    ord_d    = ord_q;
    comp_d   = comp_q;
    p_d      = p_q;
    k_d      = k_q;
    pend_v_d = pend_v_q;
    pend_s_d = pend_s_q;
    pend_t_d = pend_t_q;
    rd_s_d   = rd_s_q;
    left_d   = left_q;
    cap_d    = cap_q;
    lo_d     = lo_q;
    hie_d    = hie_q;
    avg_d    = avg_q;
    j_d      = j_q;
    pass_d   = pass_q;
    sort2_d  = sort2_q;
    out_v_d  = out_v_q && !out_o.ready;
    out_s_d  = out_s_q;
    out_t_d  = out_t_q;
    out_st_d = out_st_q;
    out_l_d  = out_l_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    div_req  = '0;
    wsum     = (FW+1)'(head_q[s_in]) + (FW+1)'(fill_q[s_in]);
    if (wsum >= (FW+1)'(QUEUE_DEPTH)) wsum = wsum - (FW+1)'(QUEUE_DEPTH);
    wpos      = QW'(wsum);
    ram_waddr = AW'(AW'(s_in) * AW'(QUEUE_DEPTH) + AW'(wpos));
    ram_raddr = AW'(AW'(id) * AW'(QUEUE_DEPTH) + AW'(head_q[id]));
    wid      = (state_q == sfsr_pkg::S_RB_HI) ? hi_id : lo_id;
    fw       = (LW+1)'(fill_q[wid]);

    case (state_q)
      sfsr_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op)
            sfsr_pkg::OP_ENQ: begin
              if (!s_act || fill_q[s_in] >= FW'(QUEUE_DEPTH)) begin
                // drop and flag
                out_v_d  = 1'b1;
                out_s_d  = s_in;
                out_t_d  = in_i.tag;
                out_st_d = sfsr_pkg::STAT_DROPPED;
                out_l_d  = 1'b1;
              end else begin
                ram_we       = 1'b1;
                fill_d[s_in] = fill_q[s_in] + 1'b1;
              end
            end
            sfsr_pkg::OP_REL: begin
              p_d = '0;
              k_d = '0;
            end
            sfsr_pkg::OP_CMP: begin
              if (s_act) begin
                if (infl_q[s_in] != '0) infl_d[s_in] = infl_q[s_in] - 1'b1;
                if (comp_hit) begin
                  comp_d = '0;
                  for (int i = 0; i < MS; i++) ord_d[i] = SW'(i);
                  left_d  = '0;
                  cap_d   = tcap_q;
                  p_d     = '0;
                  j_d     = '0;
                  pass_d  = '0;
                  sort2_d = 1'b0;
                  lo_d    = '0;
                  hie_d   = n;
                end else begin
                  comp_d = comp_inc[sfsr_pkg::CAPW-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      sfsr_pkg::S_REL_SCAN: begin
        if (!scan_end) begin
          if (id_ok) begin
            // read the head tag, advance the queue
            ram_re     = 1'b1;
            head_d[id] = (head_q[id] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[id] + 1'b1;
            fill_d[id] = fill_q[id] - 1'b1;
            infl_d[id] = infl_q[id] + 1'b1;
            k_d        = k_q + 1'b1;
            rd_s_d     = id;
          end else begin
            p_d = p_q + 1'b1;
          end
        end
      end
      sfsr_pkg::S_REL_CAPT: begin
        if (!pend_v_q || out_ld) begin
          if (pend_v_q) begin
            out_v_d  = 1'b1;
            out_s_d  = pend_s_q;
            out_t_d  = pend_t_q;
            out_st_d = sfsr_pkg::STAT_RELEASED;
            out_l_d  = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_s_d = rd_s_q;
          pend_t_d = ram_rdata;
        end
      end
      sfsr_pkg::S_REL_FLUSH: begin
        if (pend_v_q && out_ld) begin
          out_v_d  = 1'b1;
          out_s_d  = pend_s_q;
          out_t_d  = pend_t_q;
          out_st_d = sfsr_pkg::STAT_RELEASED;
          out_l_d  = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      sfsr_pkg::S_RB_SUM: begin
        if (p_q < n) begin
          left_d = left_q + LEFTW'(fill_q[p_q[SW-1:0]]);
          p_d    = p_q + 1'b1;
        end
      end
      sfsr_pkg::S_RB_SORT: begin
        if (ka > kb) begin
          ord_d[j_q]        = sb;
          ord_d[j_q + 1'b1] = sa;
        end
        if (NW'(j_q) == nm2) begin
          j_d    = '0;
          pass_d = pass_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      sfsr_pkg::S_RB_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = sfsr_pkg::NUMW'({cap_q, 1'b0}) + sfsr_pkg::NUMW'(hie_q - lo_q);
        div_req.den   = sfsr_pkg::DENW'({hie_q - lo_q, 1'b0});
      end
      sfsr_pkg::S_RB_WAIT: begin
        avg_d = LW'(div_quo);
      end
      sfsr_pkg::S_RB_DECIDE: begin
        p_d = lo_q;
      end
      sfsr_pkg::S_RB_ALL: begin
        lim_d[ord_q[p_q[SW-1:0]]] = avg_q;
        p_d = p_q + 1'b1;
        if (p_q + 1'b1 == hie_q) begin
          j_d     = '0;
          pass_d  = '0;
          sort2_d = 1'b1;
        end
      end
      sfsr_pkg::S_RB_HI, sfsr_pkg::S_RB_LO: begin
        if ((state_q == sfsr_pkg::S_RB_HI) ? hi_step : lo_step) begin
          // pin this stream at its fill level, take it out of the pool
          lim_d[wid] = LW'(fw);
          cap_d  = ((LW+1)'(cap_q) > fw) ? sfsr_pkg::CAPW'((LW+1)'(cap_q) - fw) : '0;
          left_d = (LEFTW'(fill_q[wid]) < left_q) ? left_q - LEFTW'(fill_q[wid]) : '0;
          if (state_q == sfsr_pkg::S_RB_HI) hie_d = hie_q - 1'b1;
          else lo_d = lo_q + 1'b1;
        end else begin
          j_d     = '0;
          pass_d  = '0;
          sort2_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfsr_pkg::S_IDLE;
      for (int i = 0; i < MS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
        infl_q[i] <= '0;
        lim_q[i]  <= LW'(sfsr_pkg::RESET_LIMIT);
        ord_q[i]  <= SW'(i);
      end
      comp_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      p_q      <= '0;
      k_q      <= '0;
      lo_q     <= '0;
      hie_q    <= '0;
      j_q      <= '0;
      pass_q   <= '0;
      sort2_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      infl_q   <= infl_d;
      lim_q    <= lim_d;
      ord_q    <= ord_d;
      comp_q   <= comp_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      p_q      <= p_d;
      k_q      <= k_d;
      lo_q     <= lo_d;
      hie_q    <= hie_d;
      j_q      <= j_d;
      pass_q   <= pass_d;
      sort2_q  <= sort2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_s_q <= pend_s_d;
    pend_t_q <= pend_t_d;
    rd_s_q   <= rd_s_d;
    left_q   <= left_d;
    cap_q    <= cap_d;
    avg_q    <= avg_d;
    out_s_q  <= out_s_d;
    out_t_q  <= out_t_d;
    out_st_q <= out_st_d;
    out_l_q  <= out_l_d;
  end
endmodule
